[rtl/funnel_path_smoother_top_macros.svh]
// ----------------------------------------------------------------------------
// funnel_path_smoother_top_macros: assertion macros
// Assertion macros used by the funnel smoother walker.
// ----------------------------------------------------------------------------
`ifndef FUNNEL_PATH_SMOOTHER_TOP_MACROS_SVH
`define FUNNEL_PATH_SMOOTHER_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/fps_pkg.sv]
// ----------------------------------------------------------------------------
// fps_pkg: shared types and codes of the funnel path smoother
// Word structs for both channels and the command codes.
// ----------------------------------------------------------------------------
package fps_pkg;
  localparam int CoordBits = 24;

  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_PORTAL = 2'd1;
  localparam logic [1:0] CMD_END    = 2'd2;

  typedef struct packed {
    logic [1:0]                  command;
    logic signed [CoordBits-1:0] a_x;
    logic signed [CoordBits-1:0] a_y;
    logic signed [CoordBits-1:0] b_x;
    logic signed [CoordBits-1:0] b_y;
  } in_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] corner_x;
    logic signed [CoordBits-1:0] corner_y;
    logic                        is_last;
    logic                        overflowed;
  } out_word_t;
endpackage

[rtl/fps_queue.sv]
// ----------------------------------------------------------------------------
// fps_queue: two-entry word queue between the front and back parts
// Lets the input side keep taking words while the walk runs.
// ----------------------------------------------------------------------------
module fps_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  fps_pkg::in_word_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output fps_pkg::in_word_t rd_data
);
  fps_pkg::in_word_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // pointer and fill count update
  always_comb begin
    wp_nxt  = wp_r ^ do_wr;
    rp_nxt  = rp_r ^ do_rd;
    cnt_nxt = cnt_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

[rtl/fps_walker.sv]
// ----------------------------------------------------------------------------
// fps_walker: back part, portal storage and funnel walk
// Stores portals, then on the end point walks the funnel one test at a time.
// ----------------------------------------------------------------------------
`include "funnel_path_smoother_top_macros.svh"
module fps_walker #(
  parameter int MAX_PORTALS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  fps_pkg::in_word_t cmd_data,
  output logic              out_valid,
  input  logic              out_ready,
  output fps_pkg::out_word_t out_data
);
  localparam int COORD_BITS = fps_pkg::CoordBits;
  localparam int Depth = MAX_PORTALS + 1;
  localparam int IW    = $clog2(Depth + 1);
  localparam int PW    = 2 * COORD_BITS;
  localparam int DW    = COORD_BITS + 1;
  localparam int MW    = 2 * DW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EMIT  = 4'd1;
  localparam logic [3:0] S_LADV  = 4'd2;
  localparam logic [3:0] S_LRD   = 4'd3;
  localparam logic [3:0] S_LMUL  = 4'd4;
  localparam logic [3:0] S_LCMP  = 4'd5;
  localparam logic [3:0] S_RADV  = 4'd6;
  localparam logic [3:0] S_RRD   = 4'd7;
  localparam logic [3:0] S_RMUL  = 4'd8;
  localparam logic [3:0] S_RCMP  = 4'd9;
  localparam logic [3:0] S_LAST  = 4'd10;
  localparam logic [3:0] S_WAIT  = 4'd11;

  // stores: {x, y}
  logic [PW-1:0] lmem_r [Depth];
  logic [PW-1:0] rmem_r [Depth];

  logic [3:0]    st_r, st_nxt;
  logic [3:0]    ret_r, ret_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [PW-1:0] start_r, start_nxt;
  logic [PW-1:0] end_r, end_nxt;
  logic [PW-1:0] org_r, org_nxt;
  logic [IW-1:0] il_r, il_nxt, ir_r, ir_nxt, al_r, al_nxt, ar_r, ar_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [PW-1:0] pl_r, pr_r, pal_r, par_r;
  logic [PW-1:0] opa, opb;
  logic signed [MW-1:0] m1_r, m2_r;
  logic [IW:0]   k_r, k_nxt;
  fps_pkg::out_word_t ob_r, ob_nxt, cn_r, cn_nxt;
  logic          ov_r, ov_nxt;

  // write port
  logic          wr_en;
  logic [IW-1:0] wr_idx;
  logic [PW-1:0] wr_l, wr_r2;

  // read addresses
  logic [IW-1:0] ra_l, ra_r, ra_al, ra_ar;

  logic signed [DW-1:0] ax, ay, bx, by;
  logic cw;

  assign cmd_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  // operand select for the multiplier from registered read data
  always_comb begin
    opa = pal_r;
    opb = pl_r;
    unique case (st_r)
      S_LRD, S_LMUL, S_LCMP: begin
        if (ph_r != 2'd0) begin
          opa = pl_r; opb = par_r;
        end
      end
      S_RRD, S_RMUL, S_RCMP: begin
        if (ph_r == 2'd0) begin
          opa = pr_r; opb = par_r;
        end else begin
          opa = pal_r; opb = pr_r;
        end
      end
      default: ;
    endcase
  end

  // ordered difference vectors for the current test
  always_comb begin
    ax = DW'($signed(opa[PW-1:COORD_BITS])) - DW'($signed(org_r[PW-1:COORD_BITS]));
    ay = DW'($signed(opa[COORD_BITS-1:0])) - DW'($signed(org_r[COORD_BITS-1:0]));
    bx = DW'($signed(opb[PW-1:COORD_BITS])) - DW'($signed(org_r[PW-1:COORD_BITS]));
    by = DW'($signed(opb[COORD_BITS-1:0])) - DW'($signed(org_r[COORD_BITS-1:0]));
  end
  assign cw = (m1_r < m2_r);

  always_ff @(posedge clk) begin
    m1_r <= ax * by;
    m2_r <= ay * bx;
  end

  // stores: one write port, registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lmem_r[wr_idx] <= wr_l;
      rmem_r[wr_idx] <= wr_r2;
    end
    pl_r  <= lmem_r[ra_l];
    pr_r  <= rmem_r[ra_r];
    pal_r <= lmem_r[ra_al];
    par_r <= rmem_r[ra_ar];
  end

  assign ra_l  = (il_r < IW'(Depth)) ? il_r : '0;
  assign ra_r  = (ir_r < IW'(Depth)) ? ir_r : '0;
  assign ra_al = al_r;
  assign ra_ar = ar_r;

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    start_nxt = start_r; end_nxt = end_r; org_nxt = org_r;
    il_nxt = il_r; ir_nxt = ir_r; al_nxt = al_r; ar_nxt = ar_r;
    ph_nxt = ph_r; k_nxt = k_r; ob_nxt = ob_r; cn_nxt = cn_r; ov_nxt = ov_r;
    wr_en = 1'b0; wr_idx = cnt_r;
    wr_l  = {cmd_data.a_x, cmd_data.a_y};
    wr_r2 = {cmd_data.b_x, cmd_data.b_y};
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd_data.command)
            fps_pkg::CMD_START: begin
              start_nxt = {cmd_data.a_x, cmd_data.a_y};
              cnt_nxt = '0; ovf_nxt = 1'b0;
            end
            fps_pkg::CMD_PORTAL: begin
              if (cnt_r >= IW'(MAX_PORTALS)) begin
                ovf_nxt = 1'b1;
              end else begin
                wr_en = 1'b1; cnt_nxt = cnt_r + 1'b1;
              end
            end
            fps_pkg::CMD_END: begin
              wr_en = 1'b1;
              wr_r2 = {cmd_data.a_x, cmd_data.a_y};
              end_nxt = {cmd_data.a_x, cmd_data.a_y};
              org_nxt = start_r;
              il_nxt = '0; ir_nxt = '0; al_nxt = '0; ar_nxt = '0;
              k_nxt = '0;
              cn_nxt.corner_x = start_r[PW-1:COORD_BITS];
              cn_nxt.corner_y = start_r[COORD_BITS-1:0];
              cn_nxt.is_last = 1'b0; cn_nxt.overflowed = ovf_r;
              ret_nxt = S_LADV;
              st_nxt = S_EMIT;
            end
            default: ;
          endcase
        end
      end
      // move the corner held in cn_r out once the output register is free
      S_EMIT: begin
        if (!ov_r || out_ready) begin
          ob_nxt = cn_r;
          ov_nxt = 1'b1; k_nxt = k_r + 1'b1; st_nxt = ret_r;
        end
      end
      S_LADV: begin
        il_nxt = il_r + 1'b1;
        st_nxt = (il_r + 1'b1 >= cnt_r + 1'b1) ? S_LAST : S_LRD;
        ph_nxt = 2'd0;
      end
      // up to two tests per arm: phase 0 tightening, phase 1 crossing
      S_LRD: st_nxt = S_LMUL;
      S_LMUL: st_nxt = S_LCMP;
      S_LCMP: begin
        if (ph_r == 2'd0) begin
          if (cw) begin
            st_nxt = S_RADV;
          end else begin
            ph_nxt = 2'd1; st_nxt = S_LMUL;
          end
        end else begin
          if (cw) begin
            if (k_r >= (IW+1)'(MAX_PORTALS + 1)) begin
              st_nxt = S_LAST;
            end else begin
              org_nxt = par_r;
              cn_nxt.corner_x = par_r[PW-1:COORD_BITS];
              cn_nxt.corner_y = par_r[COORD_BITS-1:0];
              cn_nxt.is_last = 1'b0;
              if (ar_r + 1'b1 > cnt_r) begin
                il_nxt = cnt_r; ir_nxt = cnt_r; al_nxt = cnt_r; ar_nxt = cnt_r;
              end else begin
                il_nxt = ar_r + 1'b1; ir_nxt = ar_r + 1'b1;
                al_nxt = ar_r + 1'b1; ar_nxt = ar_r + 1'b1;
              end
              ret_nxt = S_RADV; st_nxt = S_EMIT;
            end
          end else begin
            al_nxt = il_r; st_nxt = S_RADV;
          end
        end
      end
      S_RADV: begin
        ir_nxt = ir_r + 1'b1;
        st_nxt = (ir_r + 1'b1 >= cnt_r + 1'b1) ? S_LAST : S_RRD;
        ph_nxt = 2'd0;
      end
      S_RRD: st_nxt = S_RMUL;
      S_RMUL: st_nxt = S_RCMP;
      S_RCMP: begin
        if (ph_r == 2'd0) begin
          if (cw) begin
            st_nxt = S_LADV;
          end else begin
            ph_nxt = 2'd1; st_nxt = S_RMUL;
          end
        end else begin
          if (cw) begin
            if (k_r >= (IW+1)'(MAX_PORTALS + 1)) begin
              st_nxt = S_LAST;
            end else begin
              org_nxt = pal_r;
              cn_nxt.corner_x = pal_r[PW-1:COORD_BITS];
              cn_nxt.corner_y = pal_r[COORD_BITS-1:0];
              cn_nxt.is_last = 1'b0;
              if (al_r + 1'b1 > cnt_r) begin
                il_nxt = cnt_r; ir_nxt = cnt_r; al_nxt = cnt_r; ar_nxt = cnt_r;
              end else begin
                il_nxt = al_r + 1'b1; ir_nxt = al_r + 1'b1;
                al_nxt = al_r + 1'b1; ar_nxt = al_r + 1'b1;
              end
              ret_nxt = S_LADV; st_nxt = S_EMIT;
            end
          end else begin
            ar_nxt = ir_r; st_nxt = S_LADV;
          end
        end
      end
      S_LAST: begin
        cn_nxt.corner_x = end_r[PW-1:COORD_BITS];
        cn_nxt.corner_y = end_r[COORD_BITS-1:0];
        cn_nxt.is_last = 1'b1;
        ret_nxt = S_WAIT; st_nxt = S_EMIT;
      end
      S_WAIT: begin
        cnt_nxt = '0; ovf_nxt = 1'b0; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ret_r <= S_IDLE; cnt_r <= '0; ovf_r <= 1'b0;
      start_r <= '0; ov_r <= 1'b0; k_r <= '0; ph_r <= 2'd0;
    end else begin
      st_r <= st_nxt; ret_r <= ret_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      start_r <= start_nxt; ov_r <= ov_nxt; k_r <= k_nxt; ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    end_r <= end_nxt; org_r <= org_nxt; ob_r <= ob_nxt; cn_r <= cn_nxt;
    il_r <= il_nxt; ir_r <= ir_nxt; al_r <= al_nxt; ar_r <= ar_nxt;
  end

  `FPS_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= IW'(MAX_PORTALS))
  `FPS_ASSERT_IMP(a_k_bound, clk, rst_n, ov_r, k_r <= (IW+1)'(MAX_PORTALS + 2))
  `FPS_ASSERT_NXT(a_hold, clk, rst_n, ov_r && !out_ready, ov_r && $stable(ob_r))
  `FPS_ASSERT_IMP(a_idle_ready, clk, rst_n, cmd_ready, st_r == S_IDLE)
endmodule

[rtl/funnel_path_smoother_top.sv]
// ----------------------------------------------------------------------------
// funnel_path_smoother_top: string pulling over a corridor of portals
// Front queue takes command words, back part stores portals and walks.
// ----------------------------------------------------------------------------
// Usage: send a start word, then portal words (left and right vertex), then
// an end word. Start and portal words give no output; the end word gives the
// path corners, start point first and end point last (is_last high).
// Both channels use valid/ready; a word moves when both are high.
// A two-word queue sits in front of the back part and registers each word;
// while the back part is idle and its output register is empty it takes
// one word per cycle, so portals load at one word a cycle.
// After the end word the walk steps each funnel arm through index step,
// store read, multiply and compare, repeating multiply and compare when
// the crossing test follows; each corner passes the emit state to load
// the output register. out_valid rises once the end word is taken and the
// emit state passed; the next word is taken once the last corner has left.
// Corners leave through one output register; when the receiver stalls, the
// walk holds and the input side fills its queue, then deasserts in_ready.
// Reset clears the portal count, the start point and the overflow flag.
// ----------------------------------------------------------------------------
module funnel_path_smoother_top #(
  parameter int MAX_PORTALS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  fps_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fps_pkg::out_word_t out_data
);
  logic              q_valid, q_ready;
  fps_pkg::in_word_t q_data;

  fps_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  fps_walker #(.MAX_PORTALS(MAX_PORTALS)) u_walker (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd_data(q_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );
endmodule

[sim/funnel_path_smoother_top_tb.sv]
// ----------------------------------------------------------------------------
// funnel_path_smoother_top_tb: self-checking bench for the funnel smoother
// Drives start, portal, end and ignored-code words, predicts the path corners with a
// behavioral funnel walk and checks every output word in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module funnel_path_smoother_top_tb;
  localparam int MaxPortals = 32;
  localparam int CycleLimit = 2000000;
  localparam int CoordW     = fps_pkg::CoordBits;
  // command code with no meaning, the block ignores it
  localparam logic [1:0] CmdIgnored = 2'd3;

  typedef logic signed [CoordW-1:0] coord_t;

  // Path state and corner prediction, plus the queue of expected corners
  class corner_board;
    coord_t                      lx[MaxPortals+1], ly[MaxPortals+1];
    coord_t                      rx[MaxPortals+1], ry[MaxPortals+1];
    coord_t                      sx, sy;
    int unsigned                 n_portals;
    bit                          dropped;
    fps_pkg::out_word_t          pending[$];
    int                          errors;

    function new();
      n_portals = 0; sx = 0; sy = 0; dropped = 0; errors = 0;
    endfunction

    // cross(l - o, r - o) < 0
    function bit is_cw(longint ox, longint oy, longint ax, longint ay,
                       longint bx, longint by);
      longint dax, day, dbx, dby;
      dax = ax - ox; day = ay - oy; dbx = bx - ox; dby = by - oy;
      return (dax * dby) < (day * dbx);
    endfunction

    function void push_corner(longint x, longint y, bit last);
      fps_pkg::out_word_t w;
      w.corner_x = x[CoordW-1:0];
      w.corner_y = y[CoordW-1:0];
      w.is_last = last;
      w.overflowed = dropped;
      pending = {pending, w};
    endfunction

    function void walk(coord_t ex, coord_t ey);
      int unsigned n, il, ir, al, ar;
      longint ox, oy;
      int k;
      n = n_portals; il = 0; ir = 0; al = 0; ar = 0;
      ox = sx; oy = sy; k = 0;
      lx[n] = ex; ly[n] = ey; rx[n] = ex; ry[n] = ey;
      push_corner(ox, oy, 1'b0); k++;
      forever begin
        il++;
        if (il >= n + 1) break;
        if (!is_cw(ox, oy, lx[al], ly[al], lx[il], ly[il])) begin
          if (is_cw(ox, oy, lx[il], ly[il], rx[ar], ry[ar])) begin
            if (k >= MaxPortals + 1) break;
            ox = rx[ar]; oy = ry[ar];
            push_corner(ox, oy, 1'b0); k++;
            ir = (ar + 1 > n) ? n : ar + 1;
            ar = ir; il = ir; al = ir;
          end else begin
            al = il;
          end
        end
        ir++;
        if (ir >= n + 1) break;
        if (!is_cw(ox, oy, rx[ir], ry[ir], rx[ar], ry[ar])) begin
          if (is_cw(ox, oy, lx[al], ly[al], rx[ir], ry[ir])) begin
            if (k >= MaxPortals + 1) break;
            ox = lx[al]; oy = ly[al];
            push_corner(ox, oy, 1'b0); k++;
            il = (al + 1 > n) ? n : al + 1;
            al = il; ir = il; ar = il;
          end else begin
            ar = ir;
          end
        end
      end
      push_corner(ex, ey, 1'b1);
    endfunction

    // Note one accepted input word
    function void note_input(fps_pkg::in_word_t w);
      case (w.command)
        fps_pkg::CMD_START: begin
          sx = w.a_x; sy = w.a_y; n_portals = 0; dropped = 0;
        end
        fps_pkg::CMD_PORTAL: begin
          if (n_portals >= MaxPortals) dropped = 1;
          else begin
            lx[n_portals] = w.a_x; ly[n_portals] = w.a_y;
            rx[n_portals] = w.b_x; ry[n_portals] = w.b_y;
            n_portals++;
          end
        end
        fps_pkg::CMD_END: begin
          walk(w.a_x, w.a_y);
          n_portals = 0; dropped = 0;
        end
        default: ;
      endcase
    endfunction

    // Check one accepted output word against the oldest expectation
    function void check_output(fps_pkg::out_word_t got);
      fps_pkg::out_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word got %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.corner_x !== exp_w.corner_x) begin
        $display("%0t: corner_x expected %h actual %h", $time, exp_w.corner_x, got.corner_x);
        errors++;
      end
      if (got.corner_y !== exp_w.corner_y) begin
        $display("%0t: corner_y expected %h actual %h", $time, exp_w.corner_y, got.corner_y);
        errors++;
      end
      if (got.is_last !== exp_w.is_last) begin
        $display("%0t: is_last expected %b actual %b", $time, exp_w.is_last, got.is_last);
        errors++;
      end
      if (got.overflowed !== exp_w.overflowed) begin
        $display("%0t: overflowed expected %b actual %b", $time, exp_w.overflowed,
                 got.overflowed);
        errors++;
      end
    endfunction
  endclass

  logic               clk, rst_n;
  logic               in_valid, in_ready, out_valid, out_ready;
  fps_pkg::in_word_t  in_data;
  fps_pkg::out_word_t out_data;
  corner_board        board;
  bit                 quiet_phase;
  bit                 long_hold;
  int                 cycles;

  funnel_path_smoother_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_data);
      if (out_valid && out_ready) board.check_output(out_data);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return CoordW'($urandom);
      1: return CoordW'($urandom_range(0, 4000)) - CoordW'(2000);
      default: return ($urandom_range(0, 1)) ? {1'b0, {(CoordW-1){1'b1}}}
                                             : {1'b1, {(CoordW-1){1'b0}}};
    endcase
  endfunction

  // Send one word, holding valid and payload until accepted
  task automatic send_word(logic [1:0] cmd, coord_t ax, coord_t ay,
                           coord_t bx, coord_t by);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk);
    end
    in_data.command = cmd;
    in_data.a_x = ax; in_data.a_y = ay; in_data.b_x = bx; in_data.b_y = by;
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 0;
  endtask

  // One path: optional start, n portals laid along a corridor or random, then end
  task automatic send_path(int n, int mode, bit with_start);
    longint x, y;
    if (with_start) begin
      send_word(fps_pkg::CMD_START, rand_coord(mode), rand_coord(mode),
                CoordW'($urandom), CoordW'($urandom));
    end
    x = 0; y = 0;
    for (int i = 0; i < n; i++) begin
      if (mode == 1) begin
        x += $urandom_range(100, 600);
        y += $signed($urandom_range(0, 800)) - 400;
        send_word(fps_pkg::CMD_PORTAL, CoordW'(x), CoordW'(y + 300),
                  CoordW'(x), CoordW'(y - 300));
      end else begin
        send_word(fps_pkg::CMD_PORTAL, rand_coord(mode), rand_coord(mode),
                  rand_coord(mode), rand_coord(mode));
      end
    end
    send_word(fps_pkg::CMD_END, rand_coord(mode), rand_coord(mode),
              CoordW'($urandom), CoordW'($urandom));
  endtask

  // Receiver: random stall bursts, one long hold-off, none in the quiet phase
  initial begin
    int stall;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready = 0;
        stall = 0;
        while (stall < 400) begin
          @(negedge clk);
          stall++;
        end
        long_hold = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_ready = 0;
        stall = $urandom_range(1, 9);
        repeat (stall - 1) @(negedge clk);
      end else begin
        out_ready = 1;
      end
    end
  end

  initial begin
    int waited;
    board = new();
    rst_n = 0; in_valid = 0; in_data = '0;
    quiet_phase = 0; long_hold = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // Directed: path with no start, empty path, extremes, overflow, ignored code
    send_path(0, 0, 0);
    send_path(0, 2, 1);
    send_word(CmdIgnored, '1, '1, '1, '1);
    send_path(1, 2, 1);
    send_path(3, 1, 1);
    send_path(2, 0, 0);
    send_word(fps_pkg::CMD_START, '0, '0, '0, '0);
    send_word(fps_pkg::CMD_PORTAL, CoordW'(100), CoordW'(100), CoordW'(100), -CoordW'(100));
    send_word(fps_pkg::CMD_PORTAL, CoordW'(200), -CoordW'(300), CoordW'(200), -CoordW'(500));
    send_word(fps_pkg::CMD_END, CoordW'(400), '0, '0, '0);
    send_path(MaxPortals + 2, 1, 1);

    // Long receiver hold-off while the sender keeps going
    long_hold = 1;
    send_path(12, 1, 1);
    send_path(4, 0, 1);

    // Random paths, mostly corridors
    for (int p = 0; p < 16; p++) begin
      if (p == 13) quiet_phase = 1;
      if ($urandom_range(0, 3) == 0) send_path($urandom_range(0, 10), 0, 1);
      else if ($urandom_range(0, 9) == 0) begin
        send_word(CmdIgnored, CoordW'($urandom), CoordW'($urandom),
                  CoordW'($urandom), CoordW'($urandom));
      end
      else send_path($urandom_range(0, 12), 1, $urandom_range(0, 7) != 0);
    end
    send_path(MaxPortals, 1, 1);

    // Drain
    waited = 0;
    while (board.pending.size() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (600) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
